### rtl/slx_pkg.sv
// shared types, codes and character classes for the symbolic language lexer
package slx_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int NRES = 4;

  typedef enum logic [4:0] {
    M_IDLE, M_IDENT, M_NUM, M_NUMDOT, M_FRAC, M_STR, M_STRESC, M_CHOPEN,
    M_CHESC, M_CHCLOSE, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_GT, M_LT,
    M_COLON, M_MINUS, M_EQ, M_BANG, M_AMP, M_BAR, M_PLUS
  } mode_t;

  typedef enum logic [1:0] {
    RK_TOKEN = 2'd0,
    RK_VALUE = 2'd1,
    RK_ERROR = 2'd2
  } rkind_t;

  localparam logic [2:0] F_SYMBOL    = 3'd0;
  localparam logic [2:0] F_COMMENT   = 3'd1;
  localparam logic [2:0] F_NL_STR    = 3'd2;
  localparam logic [2:0] F_ESCAPE    = 3'd3;
  localparam logic [2:0] F_OPEN_STR  = 3'd4;
  localparam logic [2:0] F_OPEN_CHR  = 3'd5;
  localparam logic [2:0] F_CHR_CLOSE = 3'd6;

  localparam logic [5:0] K_STR     = 6'd0;
  localparam logic [5:0] K_CHAR    = 6'd1;
  localparam logic [5:0] K_FLOAT   = 6'd2;
  localparam logic [5:0] K_INT     = 6'd3;
  localparam logic [5:0] K_I       = 6'd4;
  localparam logic [5:0] K_II      = 6'd5;
  localparam logic [5:0] K_CI      = 6'd6;
  localparam logic [5:0] K_CII     = 6'd7;
  localparam logic [5:0] K_F       = 6'd8;
  localparam logic [5:0] K_CF      = 6'd9;
  localparam logic [5:0] K_B       = 6'd10;
  localparam logic [5:0] K_S       = 6'd11;
  localparam logic [5:0] K_C       = 6'd12;
  localparam logic [5:0] K_UNDER   = 6'd13;
  localparam logic [5:0] K_IDENT   = 6'd14;
  localparam logic [5:0] K_SHR     = 6'd15;
  localparam logic [5:0] K_GE      = 6'd16;
  localparam logic [5:0] K_GT      = 6'd17;
  localparam logic [5:0] K_SHL     = 6'd18;
  localparam logic [5:0] K_LARROW  = 6'd19;
  localparam logic [5:0] K_LE      = 6'd20;
  localparam logic [5:0] K_LT      = 6'd21;
  localparam logic [5:0] K_ASSIGN  = 6'd22;
  localparam logic [5:0] K_COLON   = 6'd23;
  localparam logic [5:0] K_RARROW  = 6'd24;
  localparam logic [5:0] K_SUBEQ   = 6'd25;
  localparam logic [5:0] K_MINUS   = 6'd26;
  localparam logic [5:0] K_EQEQ    = 6'd27;
  localparam logic [5:0] K_EQ      = 6'd28;
  localparam logic [5:0] K_NE      = 6'd29;
  localparam logic [5:0] K_BANG    = 6'd30;
  localparam logic [5:0] K_ANDAND  = 6'd31;
  localparam logic [5:0] K_AMP     = 6'd32;
  localparam logic [5:0] K_OROR    = 6'd33;
  localparam logic [5:0] K_ADDEQ   = 6'd34;
  localparam logic [5:0] K_PLUS    = 6'd35;
  localparam logic [5:0] K_DIV     = 6'd43;
  localparam logic [5:0] K_DOT     = 6'd52;
  localparam logic [5:0] K_NEWLINE = 6'd53;
  localparam logic [5:0] K_EOF     = 6'd54;
  localparam logic [5:0] K_NONE    = 6'd63;

  typedef struct packed {
    rkind_t      kind;
    logic [5:0]  token_kind;
    logic [2:0]  fault;
    logic [15:0] start_line;
    logic [15:0] start_col;
    logic [7:0]  text_byte;
    logic [15:0] text_len;
    logic        last;
  } res_t;

  function automatic res_t mk_res(rkind_t k, logic [5:0] tk, logic [2:0] f,
                                  logic [15:0] ln, logic [15:0] cl,
                                  logic [7:0] b, logic [15:0] len);
    res_t r;
    r.kind = k; r.token_kind = tk; r.fault = f; r.start_line = ln;
    r.start_col = cl; r.text_byte = b; r.text_len = len; r.last = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      "@": k = 6'd36;  "%": k = 6'd37;  "#": k = 6'd38;  "^": k = 6'd39;
      "$": k = 6'd40;  "*": k = 6'd41;  "?": k = 6'd42;  "(": k = 6'd44;
      ")": k = 6'd45;  "{": k = 6'd46;  "}": k = 6'd47;  "[": k = 6'd48;
      "]": k = 6'd49;  ",": k = 6'd50;  ";": k = 6'd51;  ".": k = K_DOT;
      8'h0a: k = K_NEWLINE;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // M_IDLE stands for "not an operator lead byte"
  function automatic mode_t op_mode(logic [7:0] c);
    mode_t m;
    unique case (c)
      ">": m = M_GT;    "<": m = M_LT;   ":": m = M_COLON;
      "-": m = M_MINUS; "=": m = M_EQ;   "!": m = M_BANG;
      "&": m = M_AMP;   "|": m = M_BAR;  "+": m = M_PLUS;
      default: m = M_IDLE;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] op_pair(mode_t m, logic [7:0] c);
    logic [5:0] k;
    k = K_NONE;
    unique case (m)
      M_GT:    if (c == ">") k = K_SHR; else if (c == "=") k = K_GE;
      M_LT:    if (c == "<") k = K_SHL; else if (c == "-") k = K_LARROW;
               else if (c == "=") k = K_LE;
      M_COLON: if (c == "=") k = K_ASSIGN;
      M_MINUS: if (c == ">") k = K_RARROW; else if (c == "=") k = K_SUBEQ;
      M_EQ:    if (c == "=") k = K_EQEQ;
      M_BANG:  if (c == "=") k = K_NE;
      M_AMP:   if (c == "&") k = K_ANDAND;
      M_BAR:   if (c == "|") k = K_OROR;
      M_PLUS:  if (c == "=") k = K_ADDEQ;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] op_single(mode_t m);
    logic [5:0] k;
    unique case (m)
      M_GT: k = K_GT;       M_LT: k = K_LT;     M_COLON: k = K_COLON;
      M_MINUS: k = K_MINUS; M_EQ: k = K_EQ;     M_BANG: k = K_BANG;
      M_AMP: k = K_AMP;     M_PLUS: k = K_PLUS;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // bit 8 flags a valid escape
  function automatic logic [8:0] esc_value(logic [7:0] c, logic [7:0] quote);
    logic [8:0] v;
    unique case (c)
      "n":  v = {1'b1, 8'h0a};
      "t":  v = {1'b1, 8'h09};
      "r":  v = {1'b1, 8'h0d};
      "\\": v = {1'b1, 8'h5c};
      default: v = (c == quote) ? {1'b1, c} : 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] ident_kind(logic [15:0] len, logic [15:0] head);
    logic [5:0] k;
    k = K_IDENT;
    if (len == 16'd1) begin
      unique case (head[7:0])
        "i": k = K_I;  "I": k = K_CI; "f": k = K_F; "F": k = K_CF;
        "b": k = K_B;  "s": k = K_S;  "c": k = K_C; "_": k = K_UNDER;
        default: k = K_IDENT;
      endcase
    end else if (len == 16'd2) begin
      if (head == {8'h69, 8'h69}) k = K_II;
      else if (head == {8'h49, 8'h49}) k = K_CII;
    end
    return k;
  endfunction

endpackage

### rtl/slx_core.sv
// lexer state registers and the combinational step that builds the results of one byte
module slx_core #(
  parameter int POS_BITS = slx_pkg::POS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            ch,
  input  logic                  end_mark,
  output slx_pkg::res_t [3:0]   res,
  output logic [2:0]            nres
);
  import slx_pkg::*;

  localparam logic [POS_BITS-1:0] PMAX = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] PONE = POS_BITS'(1);

  mode_t               mode_r, mode_nxt;
  logic [7:0]          held_r, held_nxt;
  logic [POS_BITS-1:0] line_r, line_nxt, col_r, col_nxt;
  logic [POS_BITS-1:0] tline_r, tline_nxt, tcol_r, tcol_nxt;
  logic [15:0]         tlen_r, tlen_nxt, whead_r, whead_nxt;
  logic                halted_r, halted_nxt;

  logic [POS_BITS-1:0] nl, nc;
  logic [8:0]          ev;
  logic [5:0]          k;
  mode_t               om;
  logic                do_idle;
  res_t [3:0]          rv;
  logic [2:0]          n;

  always_comb begin
    mode_nxt = mode_r; held_nxt = held_r; line_nxt = line_r; col_nxt = col_r;
    tline_nxt = tline_r; tcol_nxt = tcol_r; tlen_nxt = tlen_r;
    whead_nxt = whead_r; halted_nxt = halted_r;
    rv = '0; n = 3'd0; do_idle = 1'b0; k = K_NONE; om = M_IDLE;
    ev = esc_value(ch, (mode_r == M_CHESC) ? 8'h27 : 8'h22);
    if (ch == 8'h0a) begin
      nl = (line_r < PMAX) ? line_r + PONE : PMAX;
      nc = PONE;
    end else begin
      nl = line_r;
      nc = (col_r < PMAX) ? col_r + PONE : PMAX;
    end

    if (halted_r) begin
      if (end_mark) begin
        mode_nxt = M_IDLE; held_nxt = '0; line_nxt = PONE; col_nxt = PONE;
        tline_nxt = PONE; tcol_nxt = PONE; tlen_nxt = '0; whead_nxt = '0;
        halted_nxt = 1'b0;
      end
    end else if (end_mark || ch == 8'd0) begin
      // end of source: flush what is pending
      unique case (mode_r)
        M_IDLE, M_LINE: ;
        M_IDENT: begin
          rv[n[1:0]] = mk_res(RK_TOKEN, ident_kind(tlen_r, whead_r), '0,
                              16'(tline_r), 16'(tcol_r), '0, tlen_r);
          n = n + 3'd1;
        end
        M_NUM, M_FRAC: begin
          rv[n[1:0]] = mk_res(RK_TOKEN, (mode_r == M_NUM) ? K_INT : K_FLOAT, '0,
                              16'(tline_r), 16'(tcol_r), '0, tlen_r);
          n = n + 3'd1;
        end
        M_NUMDOT: begin
          rv[n[1:0]] = mk_res(RK_TOKEN, K_INT, '0, 16'(tline_r), 16'(tcol_r),
                              '0, tlen_r);
          n = n + 3'd1;
          rv[n[1:0]] = mk_res(RK_TOKEN, K_DOT, '0, 16'(line_r), whead_r, '0, '0);
          n = n + 3'd1;
        end
        M_SLASH: begin
          rv[n[1:0]] = mk_res(RK_TOKEN, K_DIV, '0, 16'(tline_r), 16'(tcol_r),
                              '0, '0);
          n = n + 3'd1;
        end
        M_STR, M_CHOPEN: begin
          rv[n[1:0]] = mk_res(RK_ERROR, '0, (mode_r == M_STR) ? F_OPEN_STR : F_OPEN_CHR,
                              16'(tline_r), 16'(tcol_r), '0, '0);
          n = n + 3'd1; halted_nxt = 1'b1;
        end
        M_STRESC, M_CHESC, M_CHCLOSE, M_BLOCK, M_BSTAR: begin
          priority if (mode_r == M_CHCLOSE) k = {3'd0, F_CHR_CLOSE};
          else if (mode_r == M_BLOCK || mode_r == M_BSTAR) k = {3'd0, F_COMMENT};
          else k = {3'd0, F_ESCAPE};
          rv[n[1:0]] = mk_res(RK_ERROR, '0, k[2:0], 16'(line_r), 16'(col_r),
                              '0, '0);
          n = n + 3'd1; halted_nxt = 1'b1;
        end
        default: begin
          k = op_single(mode_r);
          if (k == K_NONE) begin
            rv[n[1:0]] = mk_res(RK_ERROR, '0, F_SYMBOL, 16'(tline_r),
                                16'(tcol_r), '0, '0);
            halted_nxt = 1'b1;
          end else begin
            rv[n[1:0]] = mk_res(RK_TOKEN, k, '0, 16'(tline_r), 16'(tcol_r),
                                '0, '0);
          end
          n = n + 3'd1;
        end
      endcase
      mode_nxt = M_IDLE;
      if (!halted_nxt) begin
        rv[n[1:0]] = mk_res(RK_TOKEN, K_EOF, '0, 16'(line_r), 16'(col_r), '0, '0);
        n = n + 3'd1;
      end
      if (end_mark) begin
        mode_nxt = M_IDLE; held_nxt = '0; line_nxt = PONE; col_nxt = PONE;
        tline_nxt = PONE; tcol_nxt = PONE; tlen_nxt = '0; whead_nxt = '0;
        halted_nxt = 1'b0;
      end else begin
        halted_nxt = 1'b1;
      end
    end else begin
      unique case (mode_r)
        M_IDLE: do_idle = 1'b1;
        M_IDENT: begin
          if (is_alpha(ch) || is_digit(ch)) begin
            if (tlen_r == 16'd1) whead_nxt = {whead_r[7:0], ch};
            if (tlen_nxt != 16'hffff) tlen_nxt = tlen_nxt + 16'd1;
            rv[n[1:0]] = mk_res(RK_VALUE, '0, '0, 16'(tline_r), 16'(tcol_r),
                                ch, tlen_nxt);
            n = n + 3'd1;
          end else begin
            rv[n[1:0]] = mk_res(RK_TOKEN, ident_kind(tlen_r, whead_r), '0,
                                16'(tline_r), 16'(tcol_r), '0, tlen_r);
            n = n + 3'd1; do_idle = 1'b1;
          end
        end
        M_NUM, M_FRAC: begin
          if (is_digit(ch)) begin
            if (tlen_nxt != 16'hffff) tlen_nxt = tlen_nxt + 16'd1;
            rv[n[1:0]] = mk_res(RK_VALUE, '0, '0, 16'(tline_r), 16'(tcol_r),
                                ch, tlen_nxt);
            n = n + 3'd1;
          end else if (mode_r == M_NUM && ch == ".") begin
            whead_nxt = 16'(col_r); mode_nxt = M_NUMDOT;
          end else begin
            rv[n[1:0]] = mk_res(RK_TOKEN, (mode_r == M_NUM) ? K_INT : K_FLOAT, '0,
                                16'(tline_r), 16'(tcol_r), '0, tlen_r);
            n = n + 3'd1; do_idle = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (is_digit(ch)) begin
            if (tlen_nxt != 16'hffff) tlen_nxt = tlen_nxt + 16'd1;
            rv[n[1:0]] = mk_res(RK_VALUE, '0, '0, 16'(tline_r), 16'(tcol_r),
                                8'h2e, tlen_nxt);
            n = n + 3'd1;
            if (tlen_nxt != 16'hffff) tlen_nxt = tlen_nxt + 16'd1;
            rv[n[1:0]] = mk_res(RK_VALUE, '0, '0, 16'(tline_r), 16'(tcol_r),
                                ch, tlen_nxt);
            n = n + 3'd1; mode_nxt = M_FRAC;
          end else begin
            rv[n[1:0]] = mk_res(RK_TOKEN, K_INT, '0, 16'(tline_r), 16'(tcol_r),
                                '0, tlen_r);
            n = n + 3'd1;
            rv[n[1:0]] = mk_res(RK_TOKEN, K_DOT, '0, 16'(line_r), whead_r, '0, '0);
            n = n + 3'd1; do_idle = 1'b1;
          end
        end
        M_STR: begin
          priority if (ch == 8'h22) begin
            rv[n[1:0]] = mk_res(RK_TOKEN, K_STR, '0, 16'(tline_r), 16'(tcol_r),
                                '0, tlen_r);
            n = n + 3'd1; mode_nxt = M_IDLE;
          end else if (ch == 8'h0a) begin
            rv[n[1:0]] = mk_res(RK_ERROR, '0, F_NL_STR, 16'(tline_r),
                                16'(tcol_r), '0, '0);
            n = n + 3'd1; halted_nxt = 1'b1; mode_nxt = M_IDLE;
          end else if (ch == 8'h5c) begin
            mode_nxt = M_STRESC;
          end else begin
            if (tlen_nxt != 16'hffff) tlen_nxt = tlen_nxt + 16'd1;
            rv[n[1:0]] = mk_res(RK_VALUE, '0, '0, 16'(tline_r), 16'(tcol_r),
                                ch, tlen_nxt);
            n = n + 3'd1;
          end
        end
        M_STRESC, M_CHESC: begin
          if (ev[8]) begin
            if (mode_r == M_STRESC) begin
              if (tlen_nxt != 16'hffff) tlen_nxt = tlen_nxt + 16'd1;
              rv[n[1:0]] = mk_res(RK_VALUE, '0, '0, 16'(tline_r), 16'(tcol_r),
                                  ev[7:0], tlen_nxt);
              n = n + 3'd1; mode_nxt = M_STR;
            end else begin
              held_nxt = ev[7:0]; mode_nxt = M_CHCLOSE;
            end
          end else begin
            rv[n[1:0]] = mk_res(RK_ERROR, '0, F_ESCAPE, 16'(nl), 16'(nc), '0, '0);
            n = n + 3'd1; halted_nxt = 1'b1; mode_nxt = M_IDLE;
          end
        end
        M_CHOPEN: begin
          priority if (ch == 8'h0a) begin
            rv[n[1:0]] = mk_res(RK_ERROR, '0, F_OPEN_CHR, 16'(tline_r),
                                16'(tcol_r), '0, '0);
            n = n + 3'd1; halted_nxt = 1'b1; mode_nxt = M_IDLE;
          end else if (ch == 8'h5c) begin
            mode_nxt = M_CHESC;
          end else begin
            held_nxt = ch; mode_nxt = M_CHCLOSE;
          end
        end
        M_CHCLOSE: begin
          if (ch == 8'h27) begin
            if (tlen_nxt != 16'hffff) tlen_nxt = tlen_nxt + 16'd1;
            rv[n[1:0]] = mk_res(RK_VALUE, '0, '0, 16'(tline_r), 16'(tcol_r),
                                held_r, tlen_nxt);
            n = n + 3'd1;
            rv[n[1:0]] = mk_res(RK_TOKEN, K_CHAR, '0, 16'(tline_r), 16'(tcol_r),
                                '0, tlen_nxt);
            n = n + 3'd1; mode_nxt = M_IDLE;
          end else begin
            rv[n[1:0]] = mk_res(RK_ERROR, '0, F_CHR_CLOSE, 16'(line_r),
                                16'(col_r), '0, '0);
            n = n + 3'd1; halted_nxt = 1'b1; mode_nxt = M_IDLE;
          end
        end
        M_SLASH: begin
          priority if (ch == "/") mode_nxt = M_LINE;
          else if (ch == "*") mode_nxt = M_BLOCK;
          else begin
            rv[n[1:0]] = mk_res(RK_TOKEN, K_DIV, '0, 16'(tline_r), 16'(tcol_r),
                                '0, '0);
            n = n + 3'd1; do_idle = 1'b1;
          end
        end
        M_LINE: if (ch == 8'h0a) do_idle = 1'b1;
        M_BLOCK: if (ch == "*") mode_nxt = M_BSTAR;
        M_BSTAR: begin
          if (ch == "/") mode_nxt = M_IDLE;
          else if (ch != "*") mode_nxt = M_BLOCK;
        end
        M_GT, M_LT, M_COLON, M_MINUS, M_EQ, M_BANG, M_AMP, M_BAR, M_PLUS: begin
          k = op_pair(mode_r, ch);
          if (k != K_NONE) begin
            rv[n[1:0]] = mk_res(RK_TOKEN, k, '0, 16'(tline_r), 16'(tcol_r), '0, '0);
            n = n + 3'd1; mode_nxt = M_IDLE;
          end else begin
            k = op_single(mode_r);
            if (k == K_NONE) begin
              // a lone bar
              rv[n[1:0]] = mk_res(RK_ERROR, '0, F_SYMBOL, 16'(tline_r),
                                  16'(tcol_r), '0, '0);
              n = n + 3'd1; halted_nxt = 1'b1; mode_nxt = M_IDLE;
            end else begin
              rv[n[1:0]] = mk_res(RK_TOKEN, k, '0, 16'(tline_r), 16'(tcol_r),
                                  '0, '0);
              n = n + 3'd1; do_idle = 1'b1;
            end
          end
        end
        default: do_idle = 1'b1;
      endcase

      // start of a new token from this byte
      if (do_idle) begin
        tline_nxt = line_r; tcol_nxt = col_r; tlen_nxt = '0; whead_nxt = '0;
        mode_nxt = M_IDLE;
        om = op_mode(ch);
        k = single_kind(ch);
        priority if (ch == 8'h20 || ch == 8'h0d || ch == 8'h09) ;
        else if (ch == "/") mode_nxt = M_SLASH;
        else if (ch == 8'h22) mode_nxt = M_STR;
        else if (ch == 8'h27) mode_nxt = M_CHOPEN;
        else if (is_digit(ch) || is_alpha(ch)) begin
          mode_nxt = is_digit(ch) ? M_NUM : M_IDENT;
          if (!is_digit(ch)) whead_nxt = {8'd0, ch};
          tlen_nxt = 16'd1;
          rv[n[1:0]] = mk_res(RK_VALUE, '0, '0, 16'(line_r), 16'(col_r), ch, 16'd1);
          n = n + 3'd1;
        end else if (om != M_IDLE) mode_nxt = om;
        else if (k != K_NONE) begin
          rv[n[1:0]] = mk_res(RK_TOKEN, k, '0, 16'(line_r), 16'(col_r), '0, '0);
          n = n + 3'd1;
        end else begin
          rv[n[1:0]] = mk_res(RK_ERROR, '0, F_SYMBOL, 16'(line_r), 16'(col_r),
                              '0, '0);
          n = n + 3'd1; halted_nxt = 1'b1;
        end
      end
      line_nxt = nl; col_nxt = nc;
    end

    if (n != 3'd0) rv[n[1:0] - 2'd1].last = 1'b1;
  end

  assign res  = rv;
  assign nres = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; held_r <= '0; line_r <= PONE; col_r <= PONE;
      tline_r <= PONE; tcol_r <= PONE; tlen_r <= '0; whead_r <= '0;
      halted_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt; held_r <= held_nxt; line_r <= line_nxt;
      col_r <= col_nxt; tline_r <= tline_nxt; tcol_r <= tcol_nxt;
      tlen_r <= tlen_nxt; whead_r <= whead_nxt; halted_r <= halted_nxt;
    end
  end

endmodule

### rtl/slx_obuf.sv
// four-slot result buffer, loaded whole and drained one result a cycle while out_ready is high
module slx_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  slx_pkg::res_t [3:0] load_res,
  input  logic [2:0]          load_n,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output slx_pkg::res_t       out_res
);
  import slx_pkg::*;

  res_t [3:0] slot_r, slot_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = cnt_r != 3'd0;
  assign out_res   = slot_r[0];
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ready);

  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (pop) begin
      slot_nxt = {res_t'('0), slot_r[3:1]};
      cnt_nxt  = cnt_r - 3'd1;
    end
    if (load) begin
      slot_nxt = load_res;
      cnt_nxt  = load_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

### rtl/symbolic_language_lexer_unit.sv
// top level of the streaming lexer for the symbolic language
//  channel | direction | handshake            | payload
//  in_     | request   | in_valid / in_ready  | ch, end_mark
//  out_    | result    | out_valid / out_ready| kind .. last, up to three per request
// one request is taken per cycle while each yields at most one result and the result
// side takes it; a request with more results holds the next one off while the result buffer
// drains one result a cycle. results appear the cycle after acceptance.
// synchronous active-low reset clears lexer state and empties the buffer.
// a stalled result side holds the buffer; input stalls while more than one result
// waits, or while one waits and is not being taken
module symbolic_language_lexer_unit #(
  parameter int POS_BITS = slx_pkg::POS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_end_mark,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [5:0]  out_token_kind,
  output logic [2:0]  out_fault,
  output logic [15:0] out_start_line,
  output logic [15:0] out_start_col,
  output logic [7:0]  out_text_byte,
  output logic [15:0] out_text_len,
  output logic        out_last
);
  import slx_pkg::*;

  res_t [3:0] step_res;
  logic [2:0] step_n;
  logic       accept;
  res_t       head;

  assign accept = in_valid && in_ready;

  slx_core #(.POS_BITS(POS_BITS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (accept),
    .ch       (in_ch),
    .end_mark (in_end_mark),
    .res      (step_res),
    .nres     (step_n)
  );

  slx_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .load_res  (step_res),
    .load_n    (step_n),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (head)
  );

  assign out_kind       = head.kind;
  assign out_token_kind = head.token_kind;
  assign out_fault      = head.fault;
  assign out_start_line = head.start_line;
  assign out_start_col  = head.start_col;
  assign out_text_byte  = head.text_byte;
  assign out_text_len   = head.text_len;
  assign out_last       = head.last;

endmodule
